>>> hw/rtl/max_pool_with_argmax_backprop_defines.svh
// Assertion macros shared by the max pool with argmax block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MAX_POOL_WITH_ARGMAX_BACKPROP_DEFINES_SVH
`define MAX_POOL_WITH_ARGMAX_BACKPROP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mpab_pkg.sv
// Types and constants for the max pool with argmax block.
// No dependencies; the position, emit and top-level files import this package.
package mpab_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int CH_BITS      = 4;
  localparam int ROW_BITS     = 6;
  localparam int COL_BITS     = 6;
  localparam int DIM_BITS     = 7;
  localparam int CHN_CFG_BITS = 5;
  localparam int POOL_BITS    = 3;
  localparam int OFF_BITS     = 4;
  localparam int STEP_BITS    = 2;
  localparam int CELL_BITS    = CH_BITS + ROW_BITS + COL_BITS;
  localparam int CFG_BITS     = 7;
  localparam int CFG_IDX_BITS = 2;

  localparam int MAX_WIDTH    = 64;
  localparam int MAX_HEIGHT   = 64;
  localparam int MAX_CHANNELS = 16;
  localparam int MAX_POOL     = 4;

  localparam int RESET_POOL   = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_POOL_SIZE     = 2'd3
  } cfg_reg_t;

  // Configuration as stored: already clamped to the legal range.
  typedef struct packed {
    logic [DIM_BITS-1:0]     width;
    logic [DIM_BITS-1:0]     height;
    logic [CHN_CFG_BITS-1:0] channels;
    logic [POOL_BITS-1:0]    pool;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [OFF_BITS-1:0]           offset;
  } line_entry_t;

  // One decoded request handed from the position stage to the emit stage.
  typedef struct packed {
    logic                          fwd;
    logic signed [SAMPLE_BITS-1:0] val;
    logic [CH_BITS-1:0]            ch;
    logic [ROW_BITS-1:0]           orow;
    logic [COL_BITS-1:0]           ocol;
    logic [OFF_BITS-1:0]           off;
    logic                          win_end;
    logic [ROW_BITS-1:0]           base_row;
    logic [COL_BITS-1:0]           base_col;
    logic [POOL_BITS-1:0]          pool;
  } item_t;

  typedef struct packed {
    logic                we;
    logic [COL_BITS-1:0] addr;
    line_entry_t         data;
  } line_wr_t;

  typedef struct packed {
    logic                 we;
    logic [CELL_BITS-1:0] addr;
    logic [OFF_BITS-1:0]  data;
  } arg_wr_t;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [CH_BITS-1:0]            ch;
    logic [ROW_BITS-1:0]           row;
    logic [COL_BITS-1:0]           col;
    logic                          last;
  } result_t;

endpackage

>>> hw/rtl/mpab_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read returns old data on a same-address write. No dependencies.
module mpab_ram #(
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 20
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mpab_position.sv
// Raster position counters and request decode for forward and backward items.
// Depends on mpab_pkg.
module mpab_position import mpab_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          accept,
  input  logic                          action,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output item_t                         item,
  output logic                          item_work
);

  localparam int RECIP3       = 43;
  localparam int RECIP3_SHIFT = 7;

  // Quotient by the pool size; divide by three via reciprocal, exact below 128.
  function automatic logic [DIM_BITS-1:0] pool_div(input logic [DIM_BITS-1:0] v,
                                                   input logic [POOL_BITS-1:0] p);
    logic [DIM_BITS+RECIP3_SHIFT-1:0] prod;
    prod = {{RECIP3_SHIFT{1'b0}}, v} * (DIM_BITS + RECIP3_SHIFT)'(RECIP3);
    case (p)
      3'd2:    return v >> 1;
      3'd3:    return DIM_BITS'(prod >> RECIP3_SHIFT);
      3'd4:    return v >> 2;
      default: return v;
    endcase
  endfunction

  logic [CH_BITS-1:0]  fwd_ch, bwd_ch;
  logic [ROW_BITS-1:0] fwd_row, bwd_row;
  logic [COL_BITS-1:0] fwd_col, bwd_col;

  logic [DIM_BITS-1:0]     pool_w, col, row, f_ocol, f_orow, rx, ry;
  logic [DIM_BITS-1:0]     col_inc, row_inc, off_full;
  logic [CHN_CFG_BITS-1:0] chn, ch_inc;
  logic                    fwd_in;
  logic [DIM_BITS-1:0]     ow, oh, bcol, brow, bcol_inc, brow_inc;
  logic [CHN_CFG_BITS-1:0] bch, bch_inc;
  logic                    bwd_empty;

  logic [CH_BITS-1:0]  fwd_ch_next, bwd_ch_next;
  logic [ROW_BITS-1:0] fwd_row_next, bwd_row_next;
  logic [COL_BITS-1:0] fwd_col_next, bwd_col_next;

  always_comb begin
    pool_w = DIM_BITS'(cfg.pool);

    // Wrap any counter left beyond its bound by a register change.
    col = ({1'b0, fwd_col} >= cfg.width)  ? '0 : {1'b0, fwd_col};
    row = ({1'b0, fwd_row} >= cfg.height) ? '0 : {1'b0, fwd_row};
    chn = ({1'b0, fwd_ch} >= cfg.channels) ? '0 : {1'b0, fwd_ch};

    f_ocol = pool_div(col, cfg.pool);
    f_orow = pool_div(row, cfg.pool);
    rx     = col - DIM_BITS'(f_ocol * pool_w);
    ry     = row - DIM_BITS'(f_orow * pool_w);
    // Inside the pooled area when the window holding this pixel fits the map.
    fwd_in = (DIM_BITS'(col - rx) + pool_w <= cfg.width) &&
             (DIM_BITS'(row - ry) + pool_w <= cfg.height);
    off_full = DIM_BITS'(ry * pool_w) + rx;

    col_inc = col + DIM_BITS'(1);
    row_inc = row + DIM_BITS'(1);
    ch_inc  = chn + CHN_CFG_BITS'(1);
    fwd_col_next = COL_BITS'(col_inc);
    fwd_row_next = ROW_BITS'(row);
    fwd_ch_next  = CH_BITS'(chn);
    if (col_inc >= cfg.width) begin
      fwd_col_next = '0;
      fwd_row_next = ROW_BITS'(row_inc);
      if (row_inc >= cfg.height) begin
        fwd_row_next = '0;
        fwd_ch_next  = (ch_inc >= cfg.channels) ? '0 : CH_BITS'(ch_inc);
      end
    end

    ow = pool_div(cfg.width, cfg.pool);
    oh = pool_div(cfg.height, cfg.pool);
    bwd_empty = (ow == '0) || (oh == '0);
    bcol = ({1'b0, bwd_col} >= ow) ? '0 : {1'b0, bwd_col};
    brow = ({1'b0, bwd_row} >= oh) ? '0 : {1'b0, bwd_row};
    bch  = ({1'b0, bwd_ch} >= cfg.channels) ? '0 : {1'b0, bwd_ch};

    bcol_inc = bcol + DIM_BITS'(1);
    brow_inc = brow + DIM_BITS'(1);
    bch_inc  = bch + CHN_CFG_BITS'(1);
    bwd_col_next = COL_BITS'(bcol_inc);
    bwd_row_next = ROW_BITS'(brow);
    bwd_ch_next  = CH_BITS'(bch);
    if (bcol_inc >= ow) begin
      bwd_col_next = '0;
      bwd_row_next = ROW_BITS'(brow_inc);
      if (brow_inc >= oh) begin
        bwd_row_next = '0;
        bwd_ch_next  = (bch_inc >= cfg.channels) ? '0 : CH_BITS'(bch_inc);
      end
    end

    item.fwd      = !action;
    item.val      = sample;
    item.ch       = action ? CH_BITS'(bch)   : CH_BITS'(chn);
    item.orow     = action ? ROW_BITS'(brow) : ROW_BITS'(f_orow);
    item.ocol     = action ? COL_BITS'(bcol) : COL_BITS'(f_ocol);
    item.off      = OFF_BITS'(off_full);
    item.win_end  = (rx == pool_w - DIM_BITS'(1)) && (ry == pool_w - DIM_BITS'(1));
    item.base_row = ROW_BITS'(brow * pool_w);
    item.base_col = COL_BITS'(bcol * pool_w);
    item.pool     = cfg.pool;
    // Drop remainder pixels and backward requests on an empty output grid.
    item_work     = action ? !bwd_empty : fwd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_ch  <= '0;
      fwd_row <= '0;
      fwd_col <= '0;
      bwd_ch  <= '0;
      bwd_row <= '0;
      bwd_col <= '0;
    end else if (accept) begin
      if (!action) begin
        fwd_ch  <= fwd_ch_next;
        fwd_row <= fwd_row_next;
        fwd_col <= fwd_col_next;
      end else if (!bwd_empty) begin
        bwd_ch  <= bwd_ch_next;
        bwd_row <= bwd_row_next;
        bwd_col <= bwd_col_next;
      end
    end
  end

endmodule

>>> hw/rtl/mpab_emit.sv
// Emit stage: line store read-modify-write with bypass, argmax write,
// backward gradient sequencer and output register. Depends on mpab_pkg.
`include "max_pool_with_argmax_backprop_defines.svh"
module mpab_emit import mpab_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  item_t               item,
  input  logic                item_work,
  input  line_entry_t         line_rdata,
  input  logic [OFF_BITS-1:0] arg_rdata,
  input  logic                out_tready,
  output logic                free,
  output line_wr_t            line_wr,
  output arg_wr_t             arg_wr,
  output logic                out_valid,
  output result_t             out_res
);

  logic                 b_valid;
  item_t                b_item;
  logic                 line_hit, arg_hit;
  line_entry_t          line_byp;
  logic [OFF_BITS-1:0]  arg_byp;
  logic [STEP_BITS-1:0] dy, dx;
  logic [OFF_BITS-1:0]  boff;

  line_entry_t          cur, upd;
  logic [OFF_BITS-1:0]  arg;
  logic [STEP_BITS-1:0] pool_m1;
  logic                 out_slot, fwd_fire, beat_fire, last_beat, b_done, emit;
  result_t              res_next;

  always_comb begin
    cur     = line_hit ? line_byp : line_rdata;
    arg     = arg_hit ? arg_byp : arg_rdata;
    pool_m1 = STEP_BITS'(b_item.pool - POOL_BITS'(1));

    // First pixel of a window restarts the running maximum; ties keep the old one.
    if (b_item.off == '0) begin
      upd.value  = b_item.val;
      upd.offset = '0;
    end else if ($signed(b_item.val) > $signed(cur.value)) begin
      upd.value  = b_item.val;
      upd.offset = b_item.off;
    end else begin
      upd = cur;
    end

    out_slot  = !out_valid || out_tready;
    fwd_fire  = b_valid && b_item.fwd && (!b_item.win_end || out_slot);
    beat_fire = b_valid && !b_item.fwd && out_slot;
    last_beat = (dy == pool_m1) && (dx == pool_m1);
    b_done    = fwd_fire || (beat_fire && last_beat);
    free      = !b_valid || b_done;
    emit      = (fwd_fire && b_item.win_end) || beat_fire;

    line_wr.we   = fwd_fire;
    line_wr.addr = b_item.ocol;
    line_wr.data = upd;

    arg_wr.we   = fwd_fire && b_item.win_end;
    arg_wr.addr = {b_item.ch, b_item.orow, b_item.ocol};
    arg_wr.data = upd.offset;

    if (b_item.fwd) begin
      res_next.kind  = 1'b0;
      res_next.value = upd.value;
      res_next.ch    = b_item.ch;
      res_next.row   = b_item.orow;
      res_next.col   = b_item.ocol;
      res_next.last  = 1'b1;
    end else begin
      res_next.kind  = 1'b1;
      res_next.value = (boff == arg) ? b_item.val : '0;
      res_next.ch    = b_item.ch;
      res_next.row   = b_item.base_row + ROW_BITS'(dy);
      res_next.col   = b_item.base_col + COL_BITS'(dx);
      res_next.last  = last_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      dy        <= '0;
      dx        <= '0;
      boff      <= '0;
    end else begin
      if (accept) begin
        b_valid <= item_work;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_tready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        dy   <= '0;
        dx   <= '0;
        boff <= '0;
      end else if (beat_fire) begin
        if (dx == pool_m1) begin
          dx <= '0;
          dy <= dy + STEP_BITS'(1);
        end else begin
          dx <= dx + STEP_BITS'(1);
        end
        boff <= boff + OFF_BITS'(1);
      end
    end
  end

  // Payload registers; the memory read issued with this request misses a
  // write landing in the same cycle, so capture that write for bypass.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_item   <= item;
      line_hit <= line_wr.we && (line_wr.addr == item.ocol);
      line_byp <= line_wr.data;
      arg_hit  <= arg_wr.we && (arg_wr.addr == {item.ch, item.orow, item.ocol});
      arg_byp  <= arg_wr.data;
    end
    if (emit) begin
      out_res <= res_next;
    end
  end

  `MPAB_ASSERT_NXT(a_line_hit_src, accept && !line_wr.we, !line_hit, "line bypass without write")
  `MPAB_ASSERT_IMP(a_beat_offset, b_valid && !b_item.fwd, boff == OFF_BITS'(dy) * OFF_BITS'(b_item.pool) + OFF_BITS'(dx), "beat offset out of step")
  `MPAB_ASSERT_IMP(a_step_in_window, b_valid && !b_item.fwd, (dx <= pool_m1) && (dy <= pool_m1), "beat outside window")

endmodule

>>> hw/rtl/max_pool_with_argmax_backprop.sv
// Top level of the max pool with argmax block: configuration registers,
// stream handshake and the position, memory and emit stages. Depends on mpab_pkg.
//
// Usage: write image_width, image_height, channel_count and pool_size through
// cfg_we/cfg_index/cfg_data while idle; values are clamped to their range.
// Requests enter on s_axis: tuser 0 is a forward pixel, tuser 1 a backward
// output gradient, tdata the Q8.8 sample. Results leave on m_axis: tuser is
// the kind, tlast marks the final result of a request.
// Forward pixels are taken one per cycle unless the output stalls; the rate
// is set by the line store read-modify-write, which bypasses a write landing
// with the next read. A window's last pixel gives its pooled maximum through
// the emit stage register and the output register. A backward request reads
// its argmax cell and emits pool_size*pool_size gradients, one per cycle
// unless output stalls; the output beat sequencer sets that rate. Remainder
// pixels and backward requests on an empty grid are taken and give no result.
// Reset zeroes the position counters and loads the default configuration;
// the line store and argmax store are not cleared. When m_axis_tready is low
// the output register holds, a request that gives a result waits in the emit
// stage, and s_axis_tready falls until the stall clears.
module max_pool_with_argmax_backprop import mpab_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [15:0]             s_axis_tdata,  // sample
  input  logic                    s_axis_tuser,  // action
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,  // result_value, channel_index,
                                                 // row_index, column_index
  output logic                    m_axis_tuser,  // kind
  output logic                    m_axis_tlast
);

  cfg_t        cfg;
  logic        accept, free, item_work;
  item_t       item;
  line_wr_t    line_wr;
  arg_wr_t     arg_wr;
  line_entry_t line_rdata;
  logic [OFF_BITS-1:0] arg_rdata;
  result_t     out_res;

  logic [DIM_BITS-1:0]     dim_in;
  logic [CHN_CFG_BITS-1:0] chn_in;
  logic [POOL_BITS-1:0]    pool_in;

  always_comb begin
    dim_in  = cfg_data[DIM_BITS-1:0];
    chn_in  = cfg_data[CHN_CFG_BITS-1:0];
    pool_in = cfg_data[POOL_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= DIM_BITS'(MAX_WIDTH);
      cfg.height   <= DIM_BITS'(MAX_HEIGHT);
      cfg.channels <= CHN_CFG_BITS'(MAX_CHANNELS);
      cfg.pool     <= POOL_BITS'(RESET_POOL);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          cfg.width <= (dim_in == '0) ? DIM_BITS'(1) :
                       (dim_in > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : dim_in;
        end
        REG_IMAGE_HEIGHT: begin
          cfg.height <= (dim_in == '0) ? DIM_BITS'(1) :
                        (dim_in > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : dim_in;
        end
        REG_CHANNEL_COUNT: begin
          cfg.channels <= (chn_in == '0) ? CHN_CFG_BITS'(1) :
                          (chn_in > CHN_CFG_BITS'(MAX_CHANNELS)) ?
                          CHN_CFG_BITS'(MAX_CHANNELS) : chn_in;
        end
        REG_POOL_SIZE: begin
          cfg.pool <= (pool_in == '0) ? POOL_BITS'(1) :
                      (pool_in > POOL_BITS'(MAX_POOL)) ? POOL_BITS'(MAX_POOL) : pool_in;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold off requests while in reset; the stages would drop them.
  assign s_axis_tready = free && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mpab_position u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .action    (s_axis_tuser),
    .sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .item      (item),
    .item_work (item_work)
  );

  mpab_ram #(
    .ADDR_BITS (COL_BITS),
    .DATA_BITS (SAMPLE_BITS + OFF_BITS)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_wr.we),
    .waddr (line_wr.addr),
    .wdata (line_wr.data),
    .re    (accept),
    .raddr (item.ocol),
    .rdata (line_rdata)
  );

  mpab_ram #(
    .ADDR_BITS (CELL_BITS),
    .DATA_BITS (OFF_BITS)
  ) u_arg_ram (
    .clk   (clk),
    .we    (arg_wr.we),
    .waddr (arg_wr.addr),
    .wdata (arg_wr.data),
    .re    (accept),
    .raddr ({item.ch, item.orow, item.ocol}),
    .rdata (arg_rdata)
  );

  mpab_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .item_work  (item_work),
    .line_rdata (line_rdata),
    .arg_rdata  (arg_rdata),
    .out_tready (m_axis_tready),
    .free       (free),
    .line_wr    (line_wr),
    .arg_wr     (arg_wr),
    .out_valid  (m_axis_tvalid),
    .out_res    (out_res)
  );

  assign m_axis_tdata = {out_res.col, out_res.row, out_res.ch, out_res.value};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

>>> tb/max_pool_with_argmax_backprop_test.sv
// Self-checking bench for max_pool_with_argmax_backprop: streams pixel and gradient requests,
// predicts pooled maxima and routed gradients in step, and checks every result beat.
// Depends on mpab_pkg and the block's top level; nothing else is read.
module max_pool_with_argmax_backprop_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mpab_pkg::*;

  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned RANDOM_REQUESTS = 300;
  localparam int unsigned PRESSURE_AFTER  = 150;
  localparam int unsigned PRESSURE_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  localparam logic ACT_FORWARD   = 1'b0;
  localparam logic ACT_BACKWARD  = 1'b1;
  localparam logic KIND_MAX      = 1'b0;
  localparam logic KIND_GRADIENT = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [SAMPLE_BITS-1:0] sample;
  } request_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [15:0]             s_axis_tdata = '0;  // sample
  logic                    s_axis_tuser = 1'b0;  // action
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [31:0]             m_axis_tdata;  // result_value, channel_index, row_index, column_index
  logic                    m_axis_tuser;  // kind
  logic                    m_axis_tlast;

  max_pool_with_argmax_backprop dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: raw register values, raster positions, line store, argmax cells.
  logic [DIM_BITS-1:0]           width_reg = 7'd64;
  logic [DIM_BITS-1:0]           height_reg = 7'd64;
  logic [CHN_CFG_BITS-1:0]       channels_reg = 5'd16;
  logic [POOL_BITS-1:0]          pool_reg = 3'd2;
  int unsigned                   fwd_ch = 0, fwd_row = 0, fwd_col = 0;
  int unsigned                   bwd_ch = 0, bwd_row = 0, bwd_col = 0;
  logic signed [SAMPLE_BITS-1:0] line_max [MAX_WIDTH];
  logic [OFF_BITS-1:0]           line_off [MAX_WIDTH];
  logic [OFF_BITS-1:0]           argmax_cells [1 << CELL_BITS];

  request_t    pending_requests [$];
  result_t     expected_beats [$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  bit          sender_steady = 1'b0;
  bit          receiver_steady = 1'b0;
  bit          pressure_done = 1'b0;
  int unsigned hold_left = 0;
  longint unsigned cycle_count = 0;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned cell_of(int unsigned ch, int unsigned orow, int unsigned ocol);
    return (ch * MAX_HEIGHT + orow) * MAX_WIDTH + ocol;
  endfunction

  // Pool a forward pixel or route a backward gradient; append the beats it causes.
  task automatic pool_and_route(input logic action, input logic signed [SAMPLE_BITS-1:0] sample);
    int unsigned w, h, c, s, ow, oh, oc, orow, ry, rx, off, arg;
    result_t beat;
    w = clamp_reg(width_reg, MAX_WIDTH);
    h = clamp_reg(height_reg, MAX_HEIGHT);
    c = clamp_reg(channels_reg, MAX_CHANNELS);
    s = clamp_reg(pool_reg, MAX_POOL);
    ow = w / s;
    oh = h / s;
    if (action == ACT_FORWARD) begin
      if (fwd_ch >= c) fwd_ch = 0;
      if (fwd_row >= h) fwd_row = 0;
      if (fwd_col >= w) fwd_col = 0;
      if (ow > 0 && oh > 0 && fwd_row < oh * s && fwd_col < ow * s) begin
        oc = fwd_col / s;
        orow = fwd_row / s;
        ry = fwd_row % s;
        rx = fwd_col % s;
        off = ry * s + rx;
        // strict greater-than: a tie keeps the earlier pixel
        if (off == 0) begin
          line_max[oc] = sample;
          line_off[oc] = '0;
        end else if (sample > line_max[oc]) begin
          line_max[oc] = sample;
          line_off[oc] = OFF_BITS'(off);
        end
        if (ry == s - 1 && rx == s - 1) begin
          argmax_cells[cell_of(fwd_ch, orow, oc)] = line_off[oc];
          beat.kind = KIND_MAX;
          beat.value = line_max[oc];
          beat.ch = CH_BITS'(fwd_ch);
          beat.row = ROW_BITS'(orow);
          beat.col = COL_BITS'(oc);
          beat.last = 1'b1;
          expected_beats.push_back(beat);
        end
      end
      fwd_col++;
      if (fwd_col >= w) begin
        fwd_col = 0;
        fwd_row++;
        if (fwd_row >= h) begin
          fwd_row = 0;
          fwd_ch++;
          if (fwd_ch >= c) fwd_ch = 0;
        end
      end
    end else if (ow > 0 && oh > 0) begin
      if (bwd_ch >= c) bwd_ch = 0;
      if (bwd_row >= oh) bwd_row = 0;
      if (bwd_col >= ow) bwd_col = 0;
      arg = argmax_cells[cell_of(bwd_ch, bwd_row, bwd_col)];
      for (int unsigned dy = 0; dy < s; dy++) begin
        for (int unsigned dx = 0; dx < s; dx++) begin
          beat.kind = KIND_GRADIENT;
          beat.value = (dy * s + dx == arg) ? sample : '0;
          beat.ch = CH_BITS'(bwd_ch);
          beat.row = ROW_BITS'(bwd_row * s + dy);
          beat.col = COL_BITS'(bwd_col * s + dx);
          beat.last = (dy == s - 1 && dx == s - 1);
          expected_beats.push_back(beat);
        end
      end
      bwd_col++;
      if (bwd_col >= ow) begin
        bwd_col = 0;
        bwd_row++;
        if (bwd_row >= oh) begin
          bwd_row = 0;
          bwd_ch++;
          if (bwd_ch >= c) bwd_ch = 0;
        end
      end
    end
  endtask

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned stall_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver: offer the next pending request, with random gaps between them.
  always @(posedge clk) begin : drive_requests
    request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pool_and_route(s_axis_tuser, s_axis_tdata);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= req.action;
          s_axis_tdata <= req.sample;
          send_gap = sender_steady ? 0 : gap_length();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if ($urandom_range(0, 63) == 0) sender_steady = !sender_steady;
    end
  end

  // Result receiver: random short and long stalls, plus one long hold-off to back up the block.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (!pressure_done && accepted_count >= PRESSURE_AFTER) begin
        pressure_done <= 1'b1;
        hold_left <= PRESSURE_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!receiver_steady && $urandom_range(0, 7) == 0) begin
        hold_left <= stall_length();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) receiver_steady <= !receiver_steady;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.value = m_axis_tdata[15:0];
      got.ch = m_axis_tdata[19:16];
      got.row = m_axis_tdata[25:20];
      got.col = m_axis_tdata[31:26];
      got.last = m_axis_tlast;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: kind %0d value %0d ch %0d row %0d col %0d last %0d",
                   got.kind, got.value, got.ch, got.row, got.col, got.last);
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.value !== want.value || got.ch !== want.ch ||
            got.row !== want.row || got.col !== want.col || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch: expected kind %0d value %0d ch %0d row %0d col %0d last %0d",
                     want.kind, want.value, want.ch, want.row, want.col, want.last);
            $display("           actual kind %0d value %0d ch %0d row %0d col %0d last %0d",
                     got.kind, got.value, got.ch, got.row, got.col, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_request(input logic action, input logic [SAMPLE_BITS-1:0] sample);
    pending_requests.push_back({action, sample});
    queued_count++;
  endtask

  task automatic write_register(input cfg_reg_t index, input logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_IMAGE_WIDTH:   width_reg = value;
      REG_IMAGE_HEIGHT:  height_reg = value;
      REG_CHANNEL_COUNT: channels_reg = value[CHN_CFG_BITS-1:0];
      REG_POOL_SIZE:     pool_reg = value[POOL_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_BITS-1:0] width_raw, input logic [CFG_BITS-1:0] height_raw,
                           input logic [CFG_BITS-1:0] channels_raw, input logic [CFG_BITS-1:0] pool_raw);
    write_register(REG_IMAGE_WIDTH, width_raw);
    write_register(REG_IMAGE_HEIGHT, height_raw);
    write_register(REG_CHANNEL_COUNT, channels_raw);
    write_register(REG_POOL_SIZE, pool_raw);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every request is taken and every result has arrived, then let the pipe drain.
  task automatic wait_idle();
    do @(posedge clk); while (accepted_count != queued_count || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Raw register value for an effective setting; sometimes out of range so that it clamps.
  function automatic logic [CFG_BITS-1:0] raw_setting(int unsigned e, int unsigned hi,
                                                      int unsigned cap);
    if (e == 1 && $urandom_range(0, 1) == 1) return '0;
    if (e == hi && $urandom_range(0, 1) == 1) return CFG_BITS'($urandom_range(hi, cap));
    return CFG_BITS'(e);
  endfunction

  task automatic random_configure(input int unsigned phase);
    int unsigned w, h, c, s;
    logic [CHN_CFG_BITS-1:0] c_low;
    case (phase)
      0: begin
        s = $urandom_range(1, 2);
        w = MAX_WIDTH;
        h = s;
        c = 1;
      end
      1: begin
        s = $urandom_range(1, 2);
        w = s;
        h = MAX_HEIGHT;
        c = 1;
      end
      2: begin
        s = $urandom_range(1, 2);
        w = s;
        h = s;
        c = MAX_CHANNELS;
      end
      default: begin
        s = $urandom_range(1, MAX_POOL);
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 10);
        c = $urandom_range(1, 3);
      end
    endcase
    // channel register keeps only its low five bits; the top two are noise
    if (c == MAX_CHANNELS) c_low = CHN_CFG_BITS'($urandom_range(MAX_CHANNELS, 31));
    else if (c == 1 && $urandom_range(0, 1) == 1) c_low = '0;
    else c_low = CHN_CFG_BITS'(c);
    configure(raw_setting(w, MAX_WIDTH, 127), raw_setting(h, MAX_HEIGHT, 127),
              {2'($urandom), c_low}, raw_setting(s, MAX_POOL, 7));
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return prev;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Queue whole frames from position zero; gradients follow pooled cells, but for an empty grid.
  task automatic queue_frames();
    int unsigned w, h, c, s, pooled, routed, frames;
    logic [SAMPLE_BITS-1:0] pixel;
    w = clamp_reg(width_reg, MAX_WIDTH);
    h = clamp_reg(height_reg, MAX_HEIGHT);
    c = clamp_reg(channels_reg, MAX_CHANNELS);
    s = clamp_reg(pool_reg, MAX_POOL);
    frames = (w * h * c <= 40) ? $urandom_range(1, 3) : 1;
    pooled = 0;
    routed = 0;
    pixel = '0;
    repeat (frames) begin
      for (int unsigned ch = 0; ch < c; ch++) begin
        for (int unsigned row = 0; row < h; row++) begin
          for (int unsigned col = 0; col < w; col++) begin
            pixel = pick_sample(pixel);
            queue_request(ACT_FORWARD, pixel);
            if (row < (h / s) * s && col < (w / s) * s && row % s == s - 1 && col % s == s - 1)
              pooled++;
            if (w / s == 0 || h / s == 0) begin
              if ($urandom_range(0, 7) == 0) queue_request(ACT_BACKWARD, SAMPLE_BITS'($urandom));
            end else begin
              while (routed < pooled && $urandom_range(0, 2) == 0) begin
                queue_request(ACT_BACKWARD, SAMPLE_BITS'($urandom));
                routed++;
              end
            end
          end
        end
      end
    end
    while (routed < pooled) begin
      queue_request(ACT_BACKWARD, SAMPLE_BITS'($urandom));
      routed++;
    end
  endtask

  initial begin : stimulus
    int unsigned random_start;
    int unsigned phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Two channels, stop partway into the second so the next setting must wrap channel and row.
    configure(7'd2, 7'd4, 7'd2, 7'd2);
    queue_request(ACT_FORWARD, 16'h7fff);
    queue_request(ACT_FORWARD, 16'h0000);
    queue_request(ACT_FORWARD, 16'h8000);
    queue_request(ACT_FORWARD, 16'h7ffe);
    queue_request(ACT_BACKWARD, 16'hffff);
    queue_request(ACT_FORWARD, 16'h0000);
    queue_request(ACT_FORWARD, 16'h0001);
    queue_request(ACT_FORWARD, 16'h0001);
    queue_request(ACT_FORWARD, 16'h0002);
    queue_request(ACT_BACKWARD, 16'h0001);
    queue_request(ACT_FORWARD, 16'h5555);
    queue_request(ACT_FORWARD, 16'haaaa);
    queue_request(ACT_FORWARD, 16'h1234);
    queue_request(ACT_FORWARD, 16'h5555);
    queue_request(ACT_BACKWARD, 16'h8000);
    wait_idle();

    // Ties on the most negative values, a remainder column, gradients at both extremes.
    configure(7'd3, 7'd2, 7'd1, 7'd2);
    queue_request(ACT_FORWARD, 16'h8000);
    queue_request(ACT_FORWARD, 16'h8000);
    queue_request(ACT_FORWARD, 16'h7fff);
    queue_request(ACT_FORWARD, 16'h8001);
    queue_request(ACT_FORWARD, 16'h8001);
    queue_request(ACT_FORWARD, 16'hffff);
    queue_request(ACT_BACKWARD, 16'h7fff);
    queue_request(ACT_BACKWARD, 16'h8000);
    wait_idle();

    // Zero width, channel count with only high bits, oversized pool: empty output grid.
    configure(7'd0, 7'd3, 7'h20, 7'd7);
    queue_request(ACT_FORWARD, 16'h1234);
    queue_request(ACT_BACKWARD, 16'h4321);
    queue_request(ACT_FORWARD, 16'h7fff);
    queue_request(ACT_BACKWARD, 16'h8000);
    queue_request(ACT_FORWARD, 16'h0000);
    wait_idle();

    random_start = queued_count;
    phase = 0;
    while (queued_count - random_start < RANDOM_REQUESTS) begin
      random_configure(phase);
      queue_frames();
      wait_idle();
      phase++;
    end

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
